// File: rtl/cdt_pkg.sv
// Shared types, constants and the segment lookup of the countdown timer.
`default_nettype none

package cdt_pkg;

  // Register map
  localparam int unsigned REG_TICKS_PER_SECOND = 0;

  localparam logic [15:0] TPS_RESET = 16'd2500;
  localparam logic [5:0]  FIELD_MAX = 6'd59;
  localparam logic [5:0]  FIELD_WRAP = 6'd60;

  // One sample of the buttons and the tick flag
  typedef struct packed {
    logic tick;
    logic adjust_button;
    logic select_minutes;
    logic start_button;
  } cdt_item_t;

  // One result item
  typedef struct packed {
    logic [6:0] tens_segments;
    logic [6:0] units_segments;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic       running_now;
    logic       alarm_on;
  } cdt_result_t;

  // Common-cathode pattern, bit 0 is segment a
  function automatic logic [6:0] seg_lookup(input logic [3:0] digit);
    logic [6:0] pattern;
    case (digit)
      4'd0: pattern = 7'd63;
      4'd1: pattern = 7'd6;
      4'd2: pattern = 7'd91;
      4'd3: pattern = 7'd79;
      4'd4: pattern = 7'd102;
      4'd5: pattern = 7'd109;
      4'd6: pattern = 7'd125;
      4'd7: pattern = 7'd7;
      4'd8: pattern = 7'd127;
      4'd9: pattern = 7'd111;
      default: pattern = 7'd0;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cdt_in_if.sv
// Channel carrying one button sample item.
`default_nettype none

interface cdt_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic adjust_button;
  logic select_minutes;
  logic start_button;

  modport source (output valid, output tick, output adjust_button,
                  output select_minutes, output start_button, input ready);
  modport sink (input valid, input tick, input adjust_button,
                input select_minutes, input start_button, output ready);
endinterface

`default_nettype wire

// File: rtl/cdt_out_if.sv
// Channel carrying one timer result item.
`default_nettype none

interface cdt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] tens_segments;
  logic [6:0] units_segments;
  logic [5:0] minutes_now;
  logic [5:0] seconds_now;
  logic       running_now;
  logic       alarm_on;

  modport source (output valid, output tens_segments, output units_segments,
                  output minutes_now, output seconds_now, output running_now,
                  output alarm_on, input ready);
  modport sink (input valid, input tens_segments, input units_segments,
                input minutes_now, input seconds_now, input running_now,
                input alarm_on, output ready);
endinterface

`default_nettype wire

// File: rtl/countdown_timer_seven_segment.sv
// Minutes:seconds countdown timer with seven-segment digit patterns.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result register is empty or results.ready is high.
// Reset (rst, synchronous): time 00:00, stopped, alarm clear, buttons disarmed,
// ticks_per_second 2500, both channel registers empty.
`default_nettype none

module countdown_timer_seven_segment
  import cdt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cdt_in_if.sink      samples,
  cdt_out_if.source   results,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        item_valid;
  cdt_item_t   item;
  logic        out_valid;
  cdt_result_t out_item;
  cdt_result_t core_result;
  logic        advance;
  logic [15:0] ticks_per_second;

  cdt_apb u_apb (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .ticks_per_second (ticks_per_second)
  );

  // Item moves into the result register when that register is free
  assign advance       = item_valid && (!out_valid || results.ready);
  assign samples.ready = !item_valid || !out_valid || results.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      item.tick           <= samples.tick;
      item.adjust_button  <= samples.adjust_button;
      item.select_minutes <= samples.select_minutes;
      item.start_button   <= samples.start_button;
    end
  end

  cdt_core u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item             (item),
    .ticks_per_second (ticks_per_second),
    .result           (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign results.valid          = out_valid;
  assign results.tens_segments  = out_item.tens_segments;
  assign results.units_segments = out_item.units_segments;
  assign results.minutes_now    = out_item.minutes_now;
  assign results.seconds_now    = out_item.seconds_now;
  assign results.running_now    = out_item.running_now;
  assign results.alarm_on       = out_item.alarm_on;

endmodule

`default_nettype wire

// File: rtl/cdt_apb.sv
// APB register file holding ticks_per_second.
`default_nettype none

module cdt_apb
  import cdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      ticks_per_second
);

  logic       reg_sel;

  // Word index decode: only index 0 exists
  assign reg_sel = (32'(paddr[2]) == REG_TICKS_PER_SECOND);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      ticks_per_second <= pwdata[15:0];
    end
  end

  // Read back
  assign prdata = reg_sel ? {16'd0, ticks_per_second} : 32'd0;

endmodule

`default_nettype wire

// File: rtl/cdt_disp.sv
// Splits a 0..59 field into digits and maps them to segment patterns.
`default_nettype none

module cdt_disp
  import cdt_pkg::*;
(
  input  wire logic [5:0] value,
  output logic [6:0]      tens_segments,
  output logic [6:0]      units_segments
);

  logic [5:0] shown;
  logic [2:0] tens;
  logic [5:0] units;

  always_comb begin
    shown = (value > FIELD_MAX) ? FIELD_MAX : value;
    // Tens digit by compare chain
    if (shown >= 6'd50)      tens = 3'd5;
    else if (shown >= 6'd40) tens = 3'd4;
    else if (shown >= 6'd30) tens = 3'd3;
    else if (shown >= 6'd20) tens = 3'd2;
    else if (shown >= 6'd10) tens = 3'd1;
    else                     tens = 3'd0;
    units = shown - 6'({tens, 3'b000} + {2'b00, tens, 1'b0});
  end

  assign tens_segments  = seg_lookup({1'b0, tens});
  assign units_segments = seg_lookup(units[3:0]);

endmodule

`default_nettype wire

// File: rtl/cdt_core.sv
// Timer state: tick prescaler, countdown, button edges and result forming.
`default_nettype none

module cdt_core
  import cdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire cdt_item_t   item,
  input  wire logic [15:0] ticks_per_second,
  output cdt_result_t      result
);

  logic [15:0] tick_count, tick_count_next, tick_inc;
  logic [5:0]  seconds_left, seconds_left_next;
  logic [5:0]  minutes_left, minutes_left_next;
  logic        running, running_next;
  logic        adjust_armed, adjust_armed_next;
  logic        start_armed, start_armed_next;
  logic        alarm_latched, alarm_latched_next;
  logic [5:0]  shown;
  logic [5:0]  field_inc;

  always_comb begin
    tick_count_next    = tick_count;
    seconds_left_next  = seconds_left;
    minutes_left_next  = minutes_left;
    running_next       = running;
    adjust_armed_next  = adjust_armed;
    start_armed_next   = start_armed;
    alarm_latched_next = alarm_latched;
    field_inc          = 6'd0;

    // Prescaler: a full second is tested on every item
    tick_inc = item.tick ? tick_count + 16'd1 : tick_count;
    tick_count_next = tick_inc;
    if (tick_inc >= ticks_per_second) begin
      tick_count_next = 16'd0;
      if (running) begin
        if (seconds_left != 6'd0) begin
          seconds_left_next = seconds_left - 6'd1;
        end else if (minutes_left != 6'd0) begin
          seconds_left_next = FIELD_MAX;
          minutes_left_next = minutes_left - 6'd1;
        end else begin
          // Expired: latch alarm, clear time, stop
          alarm_latched_next = 1'b1;
          seconds_left_next  = 6'd0;
          minutes_left_next  = 6'd0;
          running_next       = 1'b0;
        end
      end
    end

    // Adjust on release, field chosen at release
    if (item.adjust_button) begin
      adjust_armed_next = 1'b1;
    end else if (adjust_armed) begin
      adjust_armed_next = 1'b0;
      if (item.select_minutes) begin
        field_inc = minutes_left_next + 6'd1;
        minutes_left_next = (field_inc >= FIELD_WRAP) ? 6'd0 : field_inc;
      end else begin
        field_inc = seconds_left_next + 6'd1;
        seconds_left_next = (field_inc >= FIELD_WRAP) ? 6'd0 : field_inc;
      end
    end

    // Start/pause toggles on release
    if (item.start_button) begin
      start_armed_next = 1'b1;
    end else if (start_armed) begin
      start_armed_next = 1'b0;
      running_next = ~running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 16'd0;
      seconds_left  <= 6'd0;
      minutes_left  <= 6'd0;
      running       <= 1'b0;
      adjust_armed  <= 1'b0;
      start_armed   <= 1'b0;
      alarm_latched <= 1'b0;
    end else if (advance) begin
      tick_count    <= tick_count_next;
      seconds_left  <= seconds_left_next;
      minutes_left  <= minutes_left_next;
      running       <= running_next;
      adjust_armed  <= adjust_armed_next;
      start_armed   <= start_armed_next;
      alarm_latched <= alarm_latched_next;
    end
  end

  // Result from the updated state
  assign shown = item.select_minutes ? minutes_left_next : seconds_left_next;

  cdt_disp u_disp (
    .value          (shown),
    .tens_segments  (result.tens_segments),
    .units_segments (result.units_segments)
  );

  assign result.minutes_now = minutes_left_next;
  assign result.seconds_now = seconds_left_next;
  assign result.running_now = running_next;
  assign result.alarm_on    = alarm_latched_next;

endmodule

`default_nettype wire
